// File: rtl/ccc_pkg.sv
// Shared types and widths for the circle-circle contact point pipeline.
`default_nettype none
package ccc_pkg;

    localparam int COORD_W    = 24;
    localparam int RAD_W      = 23;
    localparam int DELTA_W    = 25;
    localparam int GUARD_BITS = 6;
    localparam int V_W        = 62;
    localparam int ROOT_W     = 31;
    localparam int SQRT_STEPS = 31;
    localparam int NUM_W      = 33;
    localparam int DEN_W      = 32;
    localparam int PROD_W     = 58;
    localparam int MAG_W      = 58;
    localparam int Q_W        = 32;
    localparam int DIV_W      = 64;
    localparam int SUM_W      = 34;

    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic signed [COORD_W-1:0] diff;
        logic                      hit;
        logic                      zero;
    } sqrt_side_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic                      hit;
        logic                      zero;
        logic                      neg_x;
        logic                      neg_y;
    } div_side_t;

endpackage
`default_nettype wire

// File: rtl/ccc_sqrt_pipe.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module ccc_sqrt_pipe
    import ccc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [V_W-1:0]    in_v,
    input  wire sqrt_side_t        in_side,
    output logic                   out_valid,
    output logic [ROOT_W-1:0]      out_root,
    output sqrt_side_t             out_side
);

    logic             valid_reg [SQRT_STEPS];
    logic [V_W-1:0]   rem_reg   [SQRT_STEPS];
    logic [V_W-1:0]   res_reg   [SQRT_STEPS];
    sqrt_side_t       side_reg  [SQRT_STEPS];

    for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_step
        localparam int J = SQRT_STEPS - 1 - s;
        localparam logic [V_W-1:0] BITV = {{(V_W-1){1'b0}}, 1'b1} << (2 * J);

        logic             vin;
        logic [V_W-1:0]   rem_in;
        logic [V_W-1:0]   res_in;
        sqrt_side_t       side_in;
        logic [V_W-1:0]   trial;
        logic [V_W-1:0]   rem_next;
        logic [V_W-1:0]   res_next;

        if (s == 0) begin : g_first
            assign vin     = in_valid;
            assign rem_in  = in_v;
            assign res_in  = '0;
            assign side_in = in_side;
        end
        else begin : g_rest
            assign vin     = valid_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign res_in  = res_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        always_comb
        begin
            trial = res_in + BITV;
            if (rem_in >= trial)
            begin
                rem_next = rem_in - trial;
                res_next = (res_in >> 1) + BITV;
            end
            else
            begin
                rem_next = rem_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else if (en)
                valid_reg[s] <= vin;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                res_reg[s]  <= res_next;
                side_reg[s] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[SQRT_STEPS-1];
    assign out_root  = res_reg[SQRT_STEPS-1][ROOT_W-1:0];
    assign out_side  = side_reg[SQRT_STEPS-1];

endmodule
`default_nettype wire

// File: rtl/ccc_div_pipe.sv
// Pipelined restoring divider, two lanes sharing one divisor.
`default_nettype none
module ccc_div_pipe
    import ccc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [MAG_W-1:0]  in_mag_x,
    input  wire logic [MAG_W-1:0]  in_mag_y,
    input  wire logic [DEN_W-1:0]  in_den,
    input  wire div_side_t         in_side,
    output logic                   out_valid,
    output logic [Q_W-1:0]         out_q_x,
    output logic [Q_W-1:0]         out_q_y,
    output div_side_t              out_side
);

    logic             valid_reg [Q_W];
    logic [MAG_W-1:0] rx_reg    [Q_W];
    logic [MAG_W-1:0] ry_reg    [Q_W];
    logic [Q_W-1:0]   qx_reg    [Q_W];
    logic [Q_W-1:0]   qy_reg    [Q_W];
    logic [DEN_W-1:0] den_reg   [Q_W];
    div_side_t        side_reg  [Q_W];

    for (genvar s = 0; s < Q_W; s++) begin : g_step
        localparam int I = Q_W - 1 - s;

        logic             vin;
        logic [MAG_W-1:0] rx_in;
        logic [MAG_W-1:0] ry_in;
        logic [Q_W-1:0]   qx_in;
        logic [Q_W-1:0]   qy_in;
        logic [DEN_W-1:0] den_in;
        div_side_t        side_in;
        logic [DIV_W-1:0] dsh;
        logic             bx;
        logic             by;
        logic [MAG_W-1:0] rx_next;
        logic [MAG_W-1:0] ry_next;

        if (s == 0) begin : g_first
            assign vin     = in_valid;
            assign rx_in   = in_mag_x;
            assign ry_in   = in_mag_y;
            assign qx_in   = '0;
            assign qy_in   = '0;
            assign den_in  = in_den;
            assign side_in = in_side;
        end
        else begin : g_rest
            assign vin     = valid_reg[s-1];
            assign rx_in   = rx_reg[s-1];
            assign ry_in   = ry_reg[s-1];
            assign qx_in   = qx_reg[s-1];
            assign qy_in   = qy_reg[s-1];
            assign den_in  = den_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        always_comb
        begin
            dsh     = DIV_W'(den_in) << I;
            bx      = DIV_W'(rx_in) >= dsh;
            by      = DIV_W'(ry_in) >= dsh;
            rx_next = bx ? rx_in - dsh[MAG_W-1:0] : rx_in;
            ry_next = by ? ry_in - dsh[MAG_W-1:0] : ry_in;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else if (en)
                valid_reg[s] <= vin;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rx_reg[s]   <= rx_next;
                ry_reg[s]   <= ry_next;
                qx_reg[s]   <= {qx_in[Q_W-2:0], bx};
                qy_reg[s]   <= {qy_in[Q_W-2:0], by};
                den_reg[s]  <= den_in;
                side_reg[s] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign out_q_x   = qx_reg[Q_W-1];
    assign out_q_y   = qy_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule
`default_nettype wire

// File: rtl/circle_circle_contact_point.sv
// Top level: circle-circle hit test and contact point, fully pipelined.
//
// Input channel: in_valid / in_stall with src_x, src_y, src_radius, dst_x,
// dst_y, dst_radius (signed Q15.8 centers, unsigned Q15.8 radii). A transfer
// happens on a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with hit, contact_x, contact_y; one
// result per input item, in order. contact_x/contact_y are zero on a miss.
// Throughput: one item per cycle while not stalled. The pipeline is the
// 31-stage square root (one root bit per stage) and the 32-stage divider (one
// quotient bit per stage), plus six stages of deltas, squares, compare,
// numerator, products and final rounding/saturation.
// The whole pipeline advances as one; when the output register holds an
// untaken result and out_stall is high, in_stall rises and every stage holds.
// Reset (rst_n, asynchronous, active low) clears all valid bits; payload
// registers are not reset.
`default_nettype none
module circle_circle_contact_point
    import ccc_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic signed [COORD_W-1:0] src_x,
    input  wire logic signed [COORD_W-1:0] src_y,
    input  wire logic [RAD_W-1:0]          src_radius,
    input  wire logic signed [COORD_W-1:0] dst_x,
    input  wire logic signed [COORD_W-1:0] dst_y,
    input  wire logic [RAD_W-1:0]          dst_radius,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           hit,
    output logic signed [COORD_W-1:0]      contact_x,
    output logic signed [COORD_W-1:0]      contact_y
);

    logic en;

    // stage 1: deltas
    logic                      v1_reg;
    sqrt_side_t                side1_reg;
    logic [COORD_W-1:0]        rsum1_reg;
    sqrt_side_t                side1_next;
    logic [COORD_W-1:0]        rsum1_next;

    // stage 2: squares
    logic                      v2_reg;
    sqrt_side_t                side2_reg;
    logic [48:0]               sqx2_reg;
    logic [48:0]               sqy2_reg;
    logic [47:0]               rsq2_reg;
    logic signed [49:0]        px2;
    logic signed [49:0]        py2;

    // stage 3: compare, radicand
    logic                      v3_reg;
    sqrt_side_t                side3_reg;
    logic [V_W-1:0]            rad3_reg;
    logic [49:0]               d2;
    sqrt_side_t                side3_next;

    // square root
    logic                      sq_valid;
    logic [ROOT_W-1:0]         sq_root;
    sqrt_side_t                sq_side;

    // stage 4: numerator, denominator
    logic                      v4_reg;
    sqrt_side_t                side4_reg;
    logic signed [NUM_W-1:0]   num4_reg;
    logic [DEN_W-1:0]          den4_reg;
    logic signed [NUM_W-1:0]   num4_next;

    // stage 5: products
    logic                      v5_reg;
    sqrt_side_t                side5_reg;
    logic signed [PROD_W-1:0]  prx5_reg;
    logic signed [PROD_W-1:0]  pry5_reg;
    logic [DEN_W-1:0]          den5_reg;
    logic [MAG_W-1:0]          abs_x;
    logic [MAG_W-1:0]          abs_y;
    logic [MAG_W-1:0]          mag_x;
    logic [MAG_W-1:0]          mag_y;
    div_side_t                 dside;

    // divider
    logic                      dv_valid;
    logic [Q_W-1:0]            dq_x;
    logic [Q_W-1:0]            dq_y;
    div_side_t                 dv_side;

    // output
    logic                      out_valid_reg;
    logic                      hit_reg;
    logic [COORD_W-1:0]        cx_reg;
    logic [COORD_W-1:0]        cy_reg;
    logic [COORD_W-1:0]        cx_next;
    logic [COORD_W-1:0]        cy_next;

    function automatic logic [COORD_W-1:0] place(input logic signed [COORD_W-1:0] base,
                                                 input logic neg,
                                                 input logic [Q_W-1:0] q);
        logic signed [SUM_W-1:0] off;
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        off = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
        s   = SUM_W'(base) + off;
        hi  = SUM_W'(8388607);
        lo  = -SUM_W'(8388608);
        if (s > hi)
            return hi[COORD_W-1:0];
        else if (s < lo)
            return lo[COORD_W-1:0];
        else
            return s[COORD_W-1:0];
    endfunction

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    always_comb
    begin
        side1_next.sx   = src_x;
        side1_next.sy   = src_y;
        side1_next.dx   = DELTA_W'(dst_x) - DELTA_W'(src_x);
        side1_next.dy   = DELTA_W'(dst_y) - DELTA_W'(src_y);
        side1_next.diff = $signed({1'b0, src_radius}) - $signed({1'b0, dst_radius});
        side1_next.hit  = 1'b0;
        side1_next.zero = 1'b0;
        rsum1_next      = {1'b0, src_radius} + {1'b0, dst_radius};
    end

    assign px2 = side1_reg.dx * side1_reg.dx;
    assign py2 = side1_reg.dy * side1_reg.dy;

    always_comb
    begin
        d2              = {1'b0, sqx2_reg} + {1'b0, sqy2_reg};
        side3_next      = side2_reg;
        side3_next.hit  = d2 <= {2'b00, rsq2_reg};
        side3_next.zero = d2 == '0;
    end

    assign num4_next = $signed({{3{sq_side.diff[COORD_W-1]}}, sq_side.diff,
                                {GUARD_BITS{1'b0}}})
                       + $signed({2'b00, sq_root});

    always_comb
    begin
        abs_x       = prx5_reg[PROD_W-1] ? MAG_W'(-prx5_reg) : MAG_W'(prx5_reg);
        abs_y       = pry5_reg[PROD_W-1] ? MAG_W'(-pry5_reg) : MAG_W'(pry5_reg);
        // add half the divisor for round-half-away
        mag_x       = abs_x + MAG_W'(den5_reg[DEN_W-1:1]);
        mag_y       = abs_y + MAG_W'(den5_reg[DEN_W-1:1]);
        dside.sx    = side5_reg.sx;
        dside.sy    = side5_reg.sy;
        dside.hit   = side5_reg.hit;
        dside.zero  = side5_reg.zero;
        dside.neg_x = prx5_reg[PROD_W-1];
        dside.neg_y = pry5_reg[PROD_W-1];
    end

    always_comb
    begin
        priority if (!dv_side.hit)
        begin
            cx_next = '0;
            cy_next = '0;
        end
        else if (dv_side.zero)
        begin
            cx_next = dv_side.sx;
            cy_next = dv_side.sy;
        end
        else
        begin
            cx_next = place(dv_side.sx, dv_side.neg_x, dq_x);
            cy_next = place(dv_side.sy, dv_side.neg_y, dq_y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= sq_valid;
            v5_reg        <= v4_reg;
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= side1_next;
            rsum1_reg <= rsum1_next;
            side2_reg <= side1_reg;
            sqx2_reg  <= px2[48:0];
            sqy2_reg  <= py2[48:0];
            rsq2_reg  <= rsum1_reg * rsum1_reg;
            side3_reg <= side3_next;
            rad3_reg  <= {d2, {(2 * GUARD_BITS){1'b0}}};
            side4_reg <= sq_side;
            num4_reg  <= num4_next;
            den4_reg  <= {sq_root, 1'b0};
            side5_reg <= side4_reg;
            prx5_reg  <= side4_reg.dx * num4_reg;
            pry5_reg  <= side4_reg.dy * num4_reg;
            den5_reg  <= den4_reg;
            hit_reg   <= dv_side.hit;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
        end
    end

    ccc_sqrt_pipe u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .in_v      (rad3_reg),
        .in_side   (side3_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    ccc_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v5_reg),
        .in_mag_x  (mag_x),
        .in_mag_y  (mag_y),
        .in_den    (den5_reg),
        .in_side   (dside),
        .out_valid (dv_valid),
        .out_q_x   (dq_x),
        .out_q_y   (dq_y),
        .out_side  (dv_side)
    );

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign contact_x = cx_reg;
    assign contact_y = cy_reg;

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> contact_x == '0 && contact_y == '0)
        else $error("miss with nonzero contact point");

    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall out of step with output");

    a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(v5_reg) && $stable(v3_reg))
        else $error("pipeline moved while stalled");

endmodule
`default_nettype wire
